// File: sv/abort_base_register_restore_core_macros.svh
// Assertion macros for the abort base register restore core.
// Used by the checker file; relies on clock and reset in the including scope.
`ifndef ABORT_BASE_REGISTER_RESTORE_CORE_MACROS_SVH
`define ABORT_BASE_REGISTER_RESTORE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset
`define ABRR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define ABRR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/abrr_pkg.sv
// Package for the abort base register restore core: beat types, codes, masks.
// No dependencies; used by every module of the core.
`timescale 1ns / 1ps

package abrr_pkg;

   // Status codes
   localparam logic [1:0] STATUS_NONE  = 2'd0;
   localparam logic [1:0] STATUS_FIXED = 2'd1;
   localparam logic [1:0] STATUS_NOFIX = 2'd2;

   // Instruction classes
   localparam logic [2:0] CLASS_SWAP   = 3'd0;
   localparam logic [2:0] CLASS_SINGLE = 3'd1;
   localparam logic [2:0] CLASS_BLOCK  = 3'd2;
   localparam logic [2:0] CLASS_COPRO  = 3'd3;
   localparam logic [2:0] CLASS_OTHER  = 3'd4;

   // Shift types
   localparam logic [1:0] SHIFT_LSL = 2'd0;
   localparam logic [1:0] SHIFT_LSR = 2'd1;
   localparam logic [1:0] SHIFT_ASR = 2'd2;
   localparam logic [1:0] SHIFT_ROR = 2'd3;

   // Decode masks and matches
   localparam logic [31:0] SWAP_MASK    = 32'h0fb0_0ff0;
   localparam logic [31:0] SWAP_MATCH   = 32'h0100_0090;
   localparam logic [31:0] SINGLE_MASK  = 32'h0c00_0000;
   localparam logic [31:0] SINGLE_MATCH = 32'h0400_0000;
   localparam logic [31:0] BLKCOP_MASK  = 32'h0e00_0000;
   localparam logic [31:0] BLOCK_MATCH  = 32'h0800_0000;
   localparam logic [31:0] COPRO_MATCH  = 32'h0c00_0000;

   localparam logic [3:0] REG_PC = 4'd15;
   localparam logic [3:0] REG_SP = 4'd13;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [31:0] instruction_word;
      logic        svc_mode;
      logic [31:0] base_value;
      logic [31:0] offset_reg_value;
      logic [31:0] shift_reg_value;
   } abrr_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  instr_class;
      logic [3:0]  base_reg;
      logic [31:0] corrected_base;
   } abrr_rsp_type;

   // Classified item handed from front to back
   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  instr_class;
      logic [3:0]  base_reg;
      logic [31:0] base_value;
      logic [31:0] offset;
      logic        down;
   } abrr_job_type;

endpackage

// File: sv/abrr_front.sv
// Front end: accepts request beats, classifies them and computes the offset.
// Depends on abrr_pkg.
`timescale 1ns / 1ps

module abrr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  abrr_pkg::abrr_req_type req_data,
   input  logic                  fix_en,
   input  logic                  q_full,
   output logic                  job_valid,
   output abrr_pkg::abrr_job_type job
);

   logic                   job_valid_ff, job_valid_in;
   abrr_pkg::abrr_job_type job_ff, job_in;
   logic                   accept;

   logic [31:0] w;
   logic [3:0]  rn;
   logic [1:0]  stype;
   logic [7:0]  amt;
   logic        amt_big;
   logic [31:0] rmv;
   logic [31:0] shifted;
   logic        reg_nofix;
   logic [4:0]  ones;

   assign accept   = req_push && !req_full;
   assign req_full = job_valid_ff && q_full;

   assign w     = req_data.instruction_word;
   assign rn    = w[19:16];
   assign stype = w[6:5];
   assign rmv   = req_data.offset_reg_value;
   assign ones  = 5'($countones(w[15:0]));

   // Work out the shift amount and the register-form cannot-fix cases
   always_comb begin
      reg_nofix = (w[3:0] == rn) || (stype == abrr_pkg::SHIFT_ROR);
      if (!w[4]) begin
         amt = {3'b000, w[11:7]};
         if (w[11:7] == 5'd0 &&
             (stype == abrr_pkg::SHIFT_LSR || stype == abrr_pkg::SHIFT_ASR)) begin
            amt = 8'd32;
         end
      end else begin
         amt = req_data.shift_reg_value[7:0];
         if (w[7] || w[11:8] == rn) begin
            reg_nofix = 1'b1;
         end
      end
      amt_big = (amt[7:5] != 3'd0);
   end

   // Barrel shift of the offset register
   always_comb begin
      unique case (stype)
         abrr_pkg::SHIFT_LSL: shifted = amt_big ? 32'd0 : (rmv << amt[4:0]);
         abrr_pkg::SHIFT_LSR: shifted = amt_big ? 32'd0 : (rmv >> amt[4:0]);
         abrr_pkg::SHIFT_ASR: shifted = amt_big ? {32{rmv[31]}}
                                                : 32'($signed(rmv) >>> amt[4:0]);
         default:             shifted = 32'd0;
      endcase
   end

   // Classify and pick status and offset
   always_comb begin
      job_in.instr_class = abrr_pkg::CLASS_OTHER;
      job_in.status      = abrr_pkg::STATUS_NONE;
      job_in.base_reg    = rn;
      job_in.base_value  = req_data.base_value;
      job_in.offset      = 32'd0;
      job_in.down        = w[23];
      priority if ((w & abrr_pkg::SWAP_MASK) == abrr_pkg::SWAP_MATCH) begin
         job_in.instr_class = abrr_pkg::CLASS_SWAP;
      end else if ((w & abrr_pkg::SINGLE_MASK) == abrr_pkg::SINGLE_MATCH) begin
         job_in.instr_class = abrr_pkg::CLASS_SINGLE;
         if (fix_en && (!w[24] || w[21])) begin
            if (rn == abrr_pkg::REG_PC || (rn == abrr_pkg::REG_SP && req_data.svc_mode)) begin
               job_in.status = abrr_pkg::STATUS_NOFIX;
            end else if (!w[25]) begin
               job_in.status = abrr_pkg::STATUS_FIXED;
               job_in.offset = {20'd0, w[11:0]};
            end else if (reg_nofix) begin
               job_in.status = abrr_pkg::STATUS_NOFIX;
            end else begin
               job_in.status = abrr_pkg::STATUS_FIXED;
               job_in.offset = shifted;
            end
         end
      end else if ((w & abrr_pkg::BLKCOP_MASK) == abrr_pkg::BLOCK_MATCH) begin
         job_in.instr_class = abrr_pkg::CLASS_BLOCK;
         if (w[21]) begin
            if (rn == abrr_pkg::REG_PC) begin
               job_in.status = abrr_pkg::STATUS_NOFIX;
            end else begin
               job_in.status = abrr_pkg::STATUS_FIXED;
               job_in.offset = {25'd0, ones, 2'b00};
            end
         end
      end else if ((w & abrr_pkg::BLKCOP_MASK) == abrr_pkg::COPRO_MATCH) begin
         job_in.instr_class = abrr_pkg::CLASS_COPRO;
         if (w[21]) begin
            if (rn == abrr_pkg::REG_PC || (rn == abrr_pkg::REG_SP && req_data.svc_mode)) begin
               job_in.status = abrr_pkg::STATUS_NOFIX;
            end else begin
               job_in.status = abrr_pkg::STATUS_FIXED;
               job_in.offset = {22'd0, w[7:0], 2'b00};
            end
         end
      end else begin
         job_in.instr_class = abrr_pkg::CLASS_OTHER;
      end
   end

   // Hold the classified beat until the queue takes it
   always_comb begin
      job_valid_in = job_valid_ff;
      if (accept) begin
         job_valid_in = 1'b1;
      end else if (job_valid_ff && !q_full) begin
         job_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
      end
      if (accept) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule

// File: sv/abrr_queue.sv
// Short queue of classified beats between front and back.
// Depends on abrr_pkg.
`timescale 1ns / 1ps

module abrr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  abrr_pkg::abrr_job_type push_data,
   output logic                   full,
   input  logic                   pop,
   output abrr_pkg::abrr_job_type pop_data,
   output logic                   empty
);

   localparam int PTR_W = (abrr_pkg::QUEUE_DEPTH > 1) ? $clog2(abrr_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(abrr_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(abrr_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(abrr_pkg::QUEUE_DEPTH);

   abrr_pkg::abrr_job_type entry_ff [abrr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/abrr_back.sv
// Back end: applies the base correction and holds the response beat.
// Depends on abrr_pkg.
`timescale 1ns / 1ps

module abrr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  abrr_pkg::abrr_job_type q_data,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output abrr_pkg::abrr_rsp_type rsp_data
);

   logic                   rsp_valid_ff;
   abrr_pkg::abrr_rsp_type rsp_ff, rsp_in;
   logic                   load;

   assign load  = !q_empty && (!rsp_valid_ff || rsp_pop);
   assign q_pop = load;

   // Undo the writeback
   always_comb begin
      rsp_in.status      = q_data.status;
      rsp_in.instr_class = q_data.instr_class;
      rsp_in.base_reg    = q_data.base_reg;
      rsp_in.corrected_base = q_data.base_value;
      if (q_data.status == abrr_pkg::STATUS_FIXED) begin
         rsp_in.corrected_base = q_data.down ? q_data.base_value - q_data.offset
                                             : q_data.base_value + q_data.offset;
      end
   end

   // Hold the response until popped, refill in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/abort_base_register_restore_core.sv
// Top level of the abort base register restore core.
// Depends on abrr_pkg, abrr_front, abrr_queue and abrr_back.
//
// Takes one aborted ARM data-transfer instruction per beat with its base, offset
// and shift register values, and returns one response beat per request: class,
// status, base register index and the base with writeback undone. One request
// can be taken every clock unless a full queue stalls the front; a response
// passes the front register, the queue and the response register. The two-entry
// queue between classification and correction absorbs short response stalls.
// csr_wr_data set to 0 leaves single load/store writeback untouched; it resets
// to 1 and should only be written while no request is in flight.
`timescale 1ns / 1ps

module abort_base_register_restore_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  abrr_pkg::abrr_req_type req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output abrr_pkg::abrr_rsp_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data
);

   logic                   fix_en_ff;
   logic                   job_valid;
   abrr_pkg::abrr_job_type job;
   logic                   q_full, q_empty, q_pop;
   abrr_pkg::abrr_job_type q_data;

   // Single-transfer fix enable
   always_ff @(posedge clock) begin
      if (reset) begin
         fix_en_ff <= 1'b1;
      end else if (csr_wr_en) begin
         fix_en_ff <= csr_wr_data;
      end
   end

   abrr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .fix_en    (fix_en_ff),
      .q_full    (q_full),
      .job_valid (job_valid),
      .job       (job)
   );

   abrr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_valid),
      .push_data (job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   abrr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/abrr_checker.sv
// Port-level checks for the abort base register restore core, bound to the top.
// Depends on abrr_pkg and abort_base_register_restore_core_macros.svh.
`timescale 1ns / 1ps
`include "abort_base_register_restore_core_macros.svh"

module abrr_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_push,
   input logic                   req_full,
   input logic                   rsp_empty,
   input logic                   rsp_pop,
   input abrr_pkg::abrr_rsp_type rsp_data
);

   // A stalled response beat holds
   `ABRR_ASSERT_NEXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data), "response beat changed while stalled")

   // Status is always one of the defined codes
   `ABRR_ASSERT_NOW(a_status_code, !rsp_empty, rsp_data.status == abrr_pkg::STATUS_NONE || rsp_data.status == abrr_pkg::STATUS_FIXED || rsp_data.status == abrr_pkg::STATUS_NOFIX, "unused status code")

   // Only transfer classes get corrected
   `ABRR_ASSERT_NOW(a_fixed_class, !rsp_empty && rsp_data.status == abrr_pkg::STATUS_FIXED, rsp_data.instr_class == abrr_pkg::CLASS_SINGLE || rsp_data.instr_class == abrr_pkg::CLASS_BLOCK || rsp_data.instr_class == abrr_pkg::CLASS_COPRO, "correction on non-transfer class")

   // Swap and other instructions are never touched
   `ABRR_ASSERT_NOW(a_swap_untouched, !rsp_empty && (rsp_data.instr_class == abrr_pkg::CLASS_SWAP || rsp_data.instr_class == abrr_pkg::CLASS_OTHER), rsp_data.status == abrr_pkg::STATUS_NONE, "swap or other with nonzero status")

   // Full never rises while requests are idle
   `ABRR_ASSERT_NEXT(a_full_source, !req_full && !req_push, !req_full, "full rose without a new request")

endmodule

bind abort_base_register_restore_core abrr_checker u_abrr_checker (.*);

// File: tb/abrr_restore_checker.sv
// Checker for the abort base register restore core: watches the request, response
// and csr channels, predicts each response and compares it field by field.
// Depends on abrr_pkg for the beat types, class, status and shift codes.
`timescale 1ns / 1ps

module abrr_restore_checker
   import abrr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  logic         req_full,
   input  abrr_req_type req_data,
   input  logic         rsp_empty,
   input  logic         rsp_pop,
   input  abrr_rsp_type rsp_data,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,
   output int unsigned  mismatches,
   output int unsigned  pending
);

   localparam int PRINT_CAP = 40;

   abrr_rsp_type restore_q[$];
   logic         single_fix;

   // Print one line per mismatch (up to a cap) and count every one
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < PRINT_CAP) begin
         $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
      end
      mismatches++;
   endtask

   // Offset of a register-form single transfer after the barrel shift
   function automatic logic [31:0] shifted_offset(input logic [1:0] kind,
                                                  input logic [8:0] amount,
                                                  input logic [31:0] value);
      logic [31:0] result;
      case (kind)
         SHIFT_LSL: begin
            result = (amount >= 9'd32) ? 32'd0 : value << amount[4:0];
         end
         SHIFT_LSR: begin
            result = (amount >= 9'd32) ? 32'd0 : value >> amount[4:0];
         end
         default: begin
            // keep the shift on its own so it stays arithmetic
            result = $signed(value) >>> amount[4:0];
            if (amount >= 9'd32) begin
               result = {32{value[31]}};
            end
         end
      endcase
      return result;
   endfunction

   // Classify the aborted instruction and undo its base writeback
   function automatic abrr_rsp_type predict_restore(input abrr_req_type beat,
                                                    input logic fix_single);
      abrr_rsp_type res;
      logic [31:0]  w;
      logic [31:0]  offset;
      logic [3:0]   rn;
      logic [8:0]   amount;
      logic         fixed;
      logic         nofix;
      int unsigned  ones;
      w      = beat.instruction_word;
      rn     = w[19:16];
      offset = '0;
      amount = '0;
      fixed  = 1'b0;
      nofix  = 1'b0;
      ones   = 0;
      res.status         = STATUS_NONE;
      res.instr_class    = CLASS_OTHER;
      res.base_reg       = rn;
      res.corrected_base = beat.base_value;

      if ((w & SWAP_MASK) == SWAP_MATCH) begin
         res.instr_class = CLASS_SWAP;
      end else if ((w & SINGLE_MASK) == SINGLE_MATCH) begin
         res.instr_class = CLASS_SINGLE;
         // post-indexed or writeback, and only under the late abort model
         if (fix_single && (!w[24] || w[21])) begin
            if (rn == REG_PC || (rn == REG_SP && beat.svc_mode)) begin
               nofix = 1'b1;
            end else if (!w[25]) begin
               offset = {20'd0, w[11:0]};
               fixed  = 1'b1;
            end else begin
               if (w[3:0] == rn || w[6:5] == SHIFT_ROR) nofix = 1'b1;
               if (!w[4]) begin
                  // immediate amount: zero means 32 for LSR and ASR
                  amount = {4'd0, w[11:7]};
                  if (amount == 9'd0 && (w[6:5] == SHIFT_LSR || w[6:5] == SHIFT_ASR)) begin
                     amount = 9'd32;
                  end
               end else begin
                  if (w[7] || w[11:8] == rn) nofix = 1'b1;
                  amount = {1'b0, beat.shift_reg_value[7:0]};
               end
               if (!nofix) begin
                  offset = shifted_offset(w[6:5], amount, beat.offset_reg_value);
                  fixed  = 1'b1;
               end
            end
         end
      end else if ((w & BLKCOP_MASK) == BLOCK_MATCH) begin
         res.instr_class = CLASS_BLOCK;
         if (w[21]) begin
            if (rn == REG_PC) begin
               nofix = 1'b1;
            end else begin
               for (int i = 0; i < 16; i++) ones += w[i];
               offset = ones * 4;
               fixed  = 1'b1;
            end
         end
      end else if ((w & BLKCOP_MASK) == COPRO_MATCH) begin
         res.instr_class = CLASS_COPRO;
         if (w[21]) begin
            if (rn == REG_PC || (rn == REG_SP && beat.svc_mode)) begin
               nofix = 1'b1;
            end else begin
               offset = {22'd0, w[7:0], 2'b00};
               fixed  = 1'b1;
            end
         end
      end

      if (nofix) begin
         res.status = STATUS_NOFIX;
      end else if (fixed) begin
         res.status         = STATUS_FIXED;
         res.corrected_base = w[23] ? beat.base_value - offset : beat.base_value + offset;
      end
      return res;
   endfunction

   // Track the csr, queue a prediction per request beat, check each response beat
   always @(posedge clock) begin : track
      abrr_rsp_type want;
      if (reset) begin
         restore_q.delete();
         single_fix <= 1'b1;
         pending    <= 0;
      end else begin
         if (csr_wr_en) single_fix <= csr_wr_data;
         if (rsp_pop && !rsp_empty) begin
            if (restore_q.size() == 0) begin
               report_mismatch("unexpected response beat", rsp_data.corrected_base, '0);
            end else begin
               want = restore_q.pop_front();
               if (rsp_data.status !== want.status) begin
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               end
               if (rsp_data.instr_class !== want.instr_class) begin
                  report_mismatch("instr_class", 32'(rsp_data.instr_class),
                                  32'(want.instr_class));
               end
               if (rsp_data.base_reg !== want.base_reg) begin
                  report_mismatch("base_reg", 32'(rsp_data.base_reg), 32'(want.base_reg));
               end
               if (rsp_data.corrected_base !== want.corrected_base) begin
                  report_mismatch("corrected_base", rsp_data.corrected_base,
                                  want.corrected_base);
               end
            end
         end
         if (req_push && !req_full) begin
            restore_q.push_back(predict_restore(req_data, single_fix));
         end
         pending <= restore_q.size();
      end
   end

endmodule

// File: tb/tb_abort_base_register_restore_core.sv
// Testbench top for the abort base register restore core: clock, reset, request
// and response traffic, csr phases and the verdict.
// Depends on abrr_pkg, abort_base_register_restore_core and abrr_restore_checker.
`timescale 1ns / 1ps

module tb_abort_base_register_restore_core;
   import abrr_pkg::*;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int SETTLE_CYCLES    = 10;
   localparam int LONG_HOLD_CYCLES = 200;

   logic         clock;
   logic         reset;
   logic         req_push;
   logic         req_full;
   abrr_req_type req_data;
   logic         rsp_empty;
   logic         rsp_pop;
   abrr_rsp_type rsp_data;
   logic         csr_wr_en;
   logic         csr_wr_data;
   logic         hold_request;
   int unsigned  mismatches;
   int unsigned  pending;
   int           cycle_count = 0;

   abort_base_register_restore_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   abrr_restore_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Mostly short gaps, a few long ones
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] random_word();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return 32'h0000_0000;
      if (roll < 16) return 32'hffff_ffff;
      if (roll < 20) return 32'h8000_0000;
      if (roll < 24) return 32'h7fff_ffff;
      return $urandom();
   endfunction

   // Mostly well-formed transfer instructions with random content
   function automatic abrr_req_type random_beat();
      abrr_req_type beat;
      logic [31:0]  w;
      int           roll;
      w    = $urandom();
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         w = (w & ~SWAP_MASK) | SWAP_MATCH;
      end else if (roll < 60) begin
         w[27:26] = 2'b01;
         w[25]    = ($urandom_range(0, 99) < 60);
         if (w[25] && w[4] && $urandom_range(0, 99) < 85) w[7] = 1'b0;
      end else if (roll < 78) begin
         w[27:25] = 3'b100;
      end else if (roll < 92) begin
         w[27:25] = 3'b110;
      end
      // steer the base onto pc or sp now and then, and operands onto the base
      roll = $urandom_range(0, 99);
      if (roll < 6) w[19:16] = REG_PC;
      else if (roll < 14) w[19:16] = REG_SP;
      if ($urandom_range(0, 99) < 5) w[3:0] = w[19:16];
      if ($urandom_range(0, 99) < 5) w[11:8] = w[19:16];
      beat.instruction_word = w;
      beat.svc_mode         = 1'($urandom_range(0, 1));
      beat.base_value       = random_word();
      beat.offset_reg_value = random_word();
      beat.shift_reg_value  = $urandom();
      if ($urandom_range(0, 1)) beat.shift_reg_value[7:0] = 8'($urandom_range(0, 40));
      return beat;
   endfunction

   // Offer one beat until taken, then hold off for the given gap
   task automatic send_beat(input abrr_req_type beat, input int gap);
      req_data <= beat;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_fields(input logic [31:0] w, input logic svc, input logic [31:0] base,
                              input logic [31:0] rmv, input logic [31:0] rsv);
      abrr_req_type beat;
      beat.instruction_word = w;
      beat.svc_mode         = svc;
      beat.base_value       = base;
      beat.offset_reg_value = rmv;
      beat.shift_reg_value  = rsv;
      send_beat(beat, idle_length());
   endtask

   // Drop push, wait for every response, then let the pipeline go quiet
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_single_fix(input logic value);
      settle();
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Random beats; every so often a stretch with no gaps
   task automatic run_random(input int count);
      for (int n = 0; n < count; n++) begin
         send_beat(random_beat(), ((n % 150) < 30) ? 0 : idle_length());
      end
   endtask

   // Response side: random pops, steady stretches, and a long hold on request
   initial begin : drain_side
      int idle;
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            idle = ((cycle_count % 600) < 80) ? 0 : idle_length();
            if (idle == 0) begin
               rsp_pop <= 1'b1;
            end else begin
               rsp_pop <= 1'b0;
               repeat (idle) @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      reset        = 1'b1;
      req_push     = 1'b0;
      req_data     = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 1'b0;
      hold_request = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Field extremes and class other
      send_fields(32'h0000_0000, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_fields(32'hffff_ffff, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      // swap
      send_fields(32'he102_1093, 1'b0, 32'h1234_5678, 32'h0, 32'h0);
      // single immediate: post-index up, pre-index writeback down, no writeback
      send_fields(32'he491_0fff, 1'b0, 32'h0000_0100, 32'h0, 32'h0);
      send_fields(32'he531_0004, 1'b0, 32'hffff_fffe, 32'h0, 32'h0);
      send_fields(32'he591_0004, 1'b0, 32'h0000_1000, 32'h0, 32'h0);
      // base pc, base sp in and out of supervisor mode
      send_fields(32'he49f_0004, 1'b0, 32'h0000_1000, 32'h0, 32'h0);
      send_fields(32'he49d_0004, 1'b1, 32'h0000_1000, 32'h0, 32'h0);
      send_fields(32'he49d_0004, 1'b0, 32'h0000_1000, 32'h0, 32'h0);
      // register offset: immediate LSL, LSR and ASR by zero meaning 32, rotate
      send_fields(32'he691_0282, 1'b0, 32'h0000_8000, 32'h0000_0011, 32'h0);
      send_fields(32'he691_0022, 1'b0, 32'h0000_8000, 32'hffff_ffff, 32'h0);
      send_fields(32'he691_0042, 1'b0, 32'h0000_8000, 32'h8000_0000, 32'h0);
      send_fields(32'he691_0062, 1'b0, 32'h0000_8000, 32'h0000_0001, 32'h0);
      // offset register equal to base
      send_fields(32'he691_0001, 1'b0, 32'h0000_8000, 32'h0000_0001, 32'h0);
      // register-held amounts: zero, 200, 40 with sign fill, 31
      send_fields(32'he691_0312, 1'b0, 32'h0000_8000, 32'h0000_0123, 32'hffff_ff00);
      send_fields(32'he691_0332, 1'b0, 32'h0000_8000, 32'hffff_ffff, 32'h0000_00c8);
      send_fields(32'he691_0352, 1'b0, 32'h0000_8000, 32'h8000_0001, 32'h0000_0028);
      send_fields(32'he691_0312, 1'b0, 32'h0000_8000, 32'h0000_0003, 32'h0000_001f);
      // register-held shift with bit 7 set, shift register equal to base
      send_fields(32'he691_0392, 1'b0, 32'h0000_8000, 32'h0000_0003, 32'h0000_0002);
      send_fields(32'he691_0113, 1'b0, 32'h0000_8000, 32'h0000_0003, 32'h0000_0002);
      // block: full list up, one register down, base pc, no writeback
      send_fields(32'he8b4_ffff, 1'b0, 32'h0000_0010, 32'h0, 32'h0);
      send_fields(32'he934_0001, 1'b0, 32'hffff_fffc, 32'h0, 32'h0);
      send_fields(32'he8bf_00ff, 1'b0, 32'h0000_0100, 32'h0, 32'h0);
      send_fields(32'he894_00ff, 1'b0, 32'h0000_0100, 32'h0, 32'h0);
      // coprocessor: largest offset, sp in supervisor mode, base pc
      send_fields(32'hecb5_01ff, 1'b0, 32'h0000_0000, 32'h0, 32'h0);
      send_fields(32'hecbd_0104, 1'b1, 32'h0000_0100, 32'h0, 32'h0);
      send_fields(32'hecbf_0104, 1'b0, 32'h0000_0100, 32'h0, 32'h0);

      // Early abort model: single transfers are left alone
      write_single_fix(1'b0);
      send_fields(32'he491_0fff, 1'b0, 32'h0000_0100, 32'h0, 32'h0);
      send_fields(32'he49f_0004, 1'b0, 32'h0000_1000, 32'h0, 32'h0);
      send_fields(32'he691_0062, 1'b0, 32'h0000_8000, 32'h0000_0001, 32'h0);
      run_random(250);

      // Late abort model, with a long response hold while requests keep coming
      write_single_fix(1'b1);
      hold_request = 1'b1;
      for (int n = 0; n < 30; n++) send_beat(random_beat(), 0);
      run_random(470);

      write_single_fix(1'b0);
      run_random(200);

      write_single_fix(1'b1);
      run_random(300);

      settle();
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
